// ===== design/tdc_pkg.sv =====
// Shared types, command codes and constants of the template detection criterion block.
`default_nettype none
package tdc_pkg;

  typedef enum logic [1:0] {
    CMD_TAP     = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  localparam int LEN_BITS     = 7;
  localparam int TAP_IDX_BITS = 6;
  localparam int LEN_RESET    = 64;
  localparam int CRIT_BITS    = 32;
  localparam int RES_BITS     = CRIT_BITS + 1;

  localparam logic [CRIT_BITS-1:0] CRIT_POS_SAT = {1'b0, {(CRIT_BITS-1){1'b1}}};
  localparam logic [CRIT_BITS-1:0] CRIT_NEG_SAT = {1'b1, {(CRIT_BITS-1){1'b0}}};

  // Width of one job handed from the front end to the back end:
  // length, dot product, template sum and square sum, data sum and square sum.
  function automatic int job_width(input int max_taps, input int sample_bits);
    int lw;
    lw = $clog2(max_taps + 1);
    return lw + 3 * (2 * sample_bits + lw) + 2 * (sample_bits + lw);
  endfunction

endpackage
`default_nettype wire

// ===== design/tdc_fifo.sv =====
// Small register queue used between the front end, the back end and the result port.
`default_nettype none
module tdc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/tdc_front.sv =====
// Front end: takes transactions, keeps the template and window stores and sums, forms dot products.
`default_nettype none
module tdc_front #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [tdc_pkg::LEN_BITS-1:0]              cfg_wdata_i,
  input  wire logic                                      push_i,
  output logic                                           full_o,
  input  wire logic [1:0]                                cmd_i,
  input  wire logic [tdc_pkg::TAP_IDX_BITS-1:0]          tap_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0]             sample_value_i,
  output logic                                           job_push_o,
  output logic [tdc_pkg::job_width(MAX_TAPS, SAMPLE_BITS)-1:0] job_data_o,
  input  wire logic                                      job_full_i
);
  import tdc_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LW = $clog2(MAX_TAPS + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int WS = SB + LW;
  localparam int WQ = 2 * SB + LW;
  localparam logic [LW-1:0] NMAX = LW'(MAX_TAPS);
  localparam logic [LW-1:0] NRST = (LEN_RESET > MAX_TAPS) ? NMAX : LW'(LEN_RESET);
  localparam logic [AW-1:0] ALAST = AW'(MAX_TAPS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAP  = 3'd1;
  localparam logic [2:0] S_SMP  = 3'd2;
  localparam logic [2:0] S_DOT  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0]              state_q;
  logic [LW-1:0]           n_q, fill_q, j_q;
  logic [AW-1:0]           wp_q, rp_q, idx_q;
  logic                    rdv_q, inlen_q;
  logic signed [SB-1:0]    x_q;
  logic signed [WS-1:0]    tsum_q, dsum_q;
  logic signed [WQ-1:0]    tsq_q, dsq_q, dot_q;
  logic [MAX_TAPS-1:0]     tvalid_q;

  logic signed [SB-1:0]    tmpl_mem [MAX_TAPS];
  logic signed [SB-1:0]    ring_mem [MAX_TAPS];
  logic signed [SB-1:0]    tmpl_rd_q, ring_rd_q;
  logic                    tv_rd_q;

  logic [AW-1:0]           tmpl_ra, ring_ra, old_addr, nwp;
  logic                    tmpl_we, ring_we, accept, idx_ok;
  logic signed [SB-1:0]    tval, oldr;
  logic signed [2*SB-1:0]  sq_x, sq_old, prod;
  logic [LW-1:0]           len_new;

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p, input logic [LW-1:0] n);
    logic [LW:0] pe, ne, r;
    pe = (LW+1)'(p);
    ne = (LW+1)'(n);
    r  = (pe >= ne) ? pe - ne : pe + (LW+1)'(MAX_TAPS) - ne;
    return r[AW-1:0];
  endfunction

  assign full_o     = (state_q != S_IDLE);
  assign accept     = push_i && (state_q == S_IDLE);
  assign idx_ok     = (32'(tap_index_i) < MAX_TAPS);
  assign job_push_o = (state_q == S_PUSH) && !job_full_i;
  assign job_data_o = {n_q, dot_q, tsum_q, tsq_q, dsum_q, dsq_q};

  assign old_addr = ring_back(wp_q, n_q);
  assign nwp      = (wp_q == ALAST) ? '0 : wp_q + 1'b1;
  assign tmpl_ra  = (state_q == S_IDLE) ? AW'(tap_index_i) : j_q[AW-1:0];
  assign ring_ra  = (state_q == S_IDLE) ? old_addr : rp_q;
  assign tmpl_we  = (state_q == S_TAP);
  assign ring_we  = (state_q == S_SMP);

  // Unwritten template entries, and the oldest window sample before the window fills, read as zero.
  assign tval   = tv_rd_q ? tmpl_rd_q : '0;
  assign oldr   = (fill_q >= n_q) ? ring_rd_q : '0;
  assign sq_x   = x_q * x_q;
  assign sq_old = (state_q == S_TAP) ? tval * tval : oldr * oldr;
  assign prod   = (state_q == S_DOT) ? tval * ring_rd_q : tval * tval;

  always_comb begin
    if (cfg_wdata_i < LEN_BITS'(2)) begin
      len_new = LW'(2);
    end else if (32'(cfg_wdata_i) > MAX_TAPS) begin
      len_new = NMAX;
    end else begin
      len_new = LW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tmpl_we) begin
      tmpl_mem[idx_q] <= x_q;
    end
    if (ring_we) begin
      ring_mem[wp_q] <= x_q;
    end
    tmpl_rd_q <= tmpl_mem[tmpl_ra];
    ring_rd_q <= ring_mem[ring_ra];
    tv_rd_q   <= tvalid_q[tmpl_ra];
    if (accept) begin
      x_q     <= sample_value_i;
      idx_q   <= AW'(tap_index_i);
      inlen_q <= (32'(tap_index_i) < 32'(n_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      n_q      <= NRST;
      fill_q   <= '0;
      wp_q     <= '0;
      rp_q     <= '0;
      j_q      <= '0;
      rdv_q    <= 1'b0;
      tsum_q   <= '0;
      tsq_q    <= '0;
      dsum_q   <= '0;
      dsq_q    <= '0;
      dot_q    <= '0;
      tvalid_q <= '0;
    end else if (cfg_we_i) begin
      n_q     <= len_new;
      fill_q  <= '0;
      wp_q    <= '0;
      dsum_q  <= '0;
      dsq_q   <= '0;
      tsum_q  <= '0;
      tsq_q   <= '0;
      j_q     <= '0;
      rdv_q   <= 1'b0;
      state_q <= S_SUM;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd_e'(cmd_i))
              CMD_TAP: begin
                if (idx_ok) begin
                  state_q <= S_TAP;
                end
              end
              CMD_SAMPLE: begin
                state_q <= S_SMP;
              end
              CMD_RESTART: begin
                fill_q <= '0;
                wp_q   <= '0;
                dsum_q <= '0;
                dsq_q  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_TAP: begin
          if (inlen_q) begin
            tsum_q <= tsum_q + WS'(x_q) - WS'(tval);
            tsq_q  <= tsq_q + WQ'(sq_x) - WQ'(sq_old);
          end
          tvalid_q[idx_q] <= 1'b1;
          state_q         <= S_IDLE;
        end
        S_SMP: begin
          dsum_q <= dsum_q - WS'(oldr) + WS'(x_q);
          dsq_q  <= dsq_q - WQ'(sq_old) + WQ'(sq_x);
          wp_q   <= nwp;
          if (fill_q < n_q) begin
            fill_q <= fill_q + 1'b1;
          end
          if ((fill_q >= n_q) || (fill_q + 1'b1 >= n_q)) begin
            j_q     <= '0;
            rdv_q   <= 1'b0;
            dot_q   <= '0;
            rp_q    <= ring_back(nwp, n_q);
            state_q <= S_DOT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DOT, S_SUM: begin
          if (j_q < n_q) begin
            j_q  <= j_q + 1'b1;
            rp_q <= (rp_q == ALAST) ? '0 : rp_q + 1'b1;
          end
          rdv_q <= (j_q < n_q);
          if (rdv_q) begin
            if (state_q == S_DOT) begin
              dot_q <= dot_q + WQ'(prod);
            end else begin
              tsum_q <= tsum_q + WS'(tval);
              tsq_q  <= tsq_q + WQ'(prod);
            end
          end
          if ((j_q == n_q) && !rdv_q) begin
            state_q <= (state_q == S_DOT) ? S_PUSH : S_IDLE;
          end
        end
        S_PUSH: begin
          if (!job_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tdc_back.sv =====
// Back end: least-squares fit terms, criterion by shift-add multiply, long division and square root.
`default_nettype none
module tdc_back #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic [tdc_pkg::job_width(MAX_TAPS, SAMPLE_BITS)-1:0] job_data_i,
  input  wire logic                                             job_empty_i,
  output logic                                                  job_pop_o,
  output logic                                                  res_push_o,
  output logic [tdc_pkg::RES_BITS-1:0]                          res_data_o,
  input  wire logic                                             res_full_i
);
  import tdc_pkg::*;

  localparam int LW = $clog2(MAX_TAPS + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int WS = SB + LW;
  localparam int WQ = 2 * SB + LW;
  localparam int W1 = 2 * SB + 2 * LW + 2;
  localparam int WX = 2 * W1;
  localparam int WP = 3 * W1;
  localparam int WN = 2 * W1 + 2 * LW + 32;
  localparam int CW = $clog2(WN + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  localparam logic [3:0] ST_NSDT = 4'd0;
  localparam logic [3:0] ST_STSD = 4'd1;
  localparam logic [3:0] ST_NSTT = 4'd2;
  localparam logic [3:0] ST_STST = 4'd3;
  localparam logic [3:0] ST_NSDD = 4'd4;
  localparam logic [3:0] ST_SDSD = 4'd5;
  localparam logic [3:0] ST_CB   = 4'd6;
  localparam logic [3:0] ST_AA   = 4'd7;
  localparam logic [3:0] ST_DB   = 4'd8;
  localparam logic [3:0] ST_NN   = 4'd9;
  localparam logic [3:0] ST_NUM  = 4'd10;

  logic [LW-1:0]          jn;
  logic signed [WQ-1:0]   jdot, jstt, jsdd;
  logic signed [WS-1:0]   jst, jsd;

  logic [2:0]             state_q;
  logic [3:0]             step_q;
  logic                   ld_q, neg_q, deg_q, ovf_q;
  logic [WP-1:0]          mx_q, mp_q, den_q;
  logic [W1-1:0]          my_q, c_q, nn_q;
  logic signed [W1-1:0]   a_q, b_q;
  logic signed [WP:0]     t_q;
  logic [WX-1:0]          aa_q;
  logic signed [WX:0]     d_q;
  logic [WN-1:0]          num_q;
  logic [WP:0]            rem_q;
  logic [63:0]            quo_q;
  logic [CW-1:0]          cnt_q;
  logic [35:0]            srem_q;
  logic [31:0]            root_q;

  logic [WP-1:0]          mx_sel;
  logic [W1-1:0]          my_sel;
  logic                   neg_sel, mul_done, bpos, dpos, big;
  logic signed [WP:0]     sr, diff;
  logic [WP:0]            rs;
  logic [35:0]            rs2, test;
  logic [CRIT_BITS-1:0]   crit;

  function automatic logic [WP-1:0] mag(input logic signed [WP:0] v);
    logic signed [WP:0] m;
    m = v[WP] ? -v : v;
    return m[WP-1:0];
  endfunction

  assign {jn, jdot, jst, jstt, jsd, jsdd} = job_data_i;

  always_comb begin
    mx_sel  = '0;
    my_sel  = '0;
    neg_sel = 1'b0;
    case (step_q)
      ST_NSDT: begin
        mx_sel  = mag((WP+1)'(jdot));
        my_sel  = W1'(jn);
        neg_sel = jdot[WQ-1];
      end
      ST_STSD: begin
        mx_sel  = mag((WP+1)'(jst));
        my_sel  = W1'(mag((WP+1)'(jsd)));
        neg_sel = jst[WS-1] ^ jsd[WS-1];
      end
      ST_NSTT: begin
        mx_sel = mag((WP+1)'(jstt));
        my_sel = W1'(jn);
      end
      ST_STST: begin
        mx_sel = mag((WP+1)'(jst));
        my_sel = W1'(mag((WP+1)'(jst)));
      end
      ST_NSDD: begin
        mx_sel = mag((WP+1)'(jsdd));
        my_sel = W1'(jn);
      end
      ST_SDSD: begin
        mx_sel = mag((WP+1)'(jsd));
        my_sel = W1'(mag((WP+1)'(jsd)));
      end
      ST_CB: begin
        mx_sel = WP'(c_q);
        my_sel = b_q;
      end
      ST_AA: begin
        mx_sel = mag((WP+1)'(a_q));
        my_sel = W1'(mag((WP+1)'(a_q)));
      end
      ST_DB: begin
        mx_sel = WP'(d_q[WX-1:0]);
        my_sel = b_q;
      end
      ST_NN: begin
        mx_sel = WP'(jn);
        my_sel = W1'(jn - 1'b1);
      end
      ST_NUM: begin
        mx_sel = WP'(aa_q);
        my_sel = nn_q;
      end
      default: begin
      end
    endcase
  end

  assign mul_done = !ld_q && (my_q == '0);
  assign sr       = neg_q ? -$signed({1'b0, mp_q}) : $signed({1'b0, mp_q});
  assign diff     = t_q - sr;
  assign bpos     = !b_q[W1-1] && (b_q != '0);
  assign dpos     = !diff[WP] && (diff != '0);

  assign rs   = {rem_q[WP-1:0], num_q[WN-1]};
  assign rs2  = {srem_q[33:0], quo_q[63:62]};
  assign test = {2'b00, root_q, 2'b01};

  assign big = ovf_q || root_q[31];
  always_comb begin
    if (deg_q) begin
      crit = '0;
    end else if (a_q[W1-1]) begin
      crit = big ? CRIT_NEG_SAT : -root_q;
    end else begin
      crit = big ? CRIT_POS_SAT : root_q;
    end
  end

  assign res_push_o = (state_q == B_OUT) && !res_full_i;
  assign job_pop_o  = res_push_o;
  assign res_data_o = {deg_q, crit};

  always_ff @(posedge clk_i) begin
    if (state_q == B_MUL) begin
      if (ld_q) begin
        mx_q  <= mx_sel;
        my_q  <= my_sel;
        neg_q <= neg_sel;
        mp_q  <= '0;
      end else if (!mul_done) begin
        if (my_q[0]) begin
          mp_q <= mp_q + mx_q;
        end
        mx_q <= {mx_q[WP-2:0], 1'b0};
        my_q <= {1'b0, my_q[W1-1:1]};
      end else begin
        case (step_q)
          ST_NSDT, ST_NSTT, ST_NSDD, ST_CB: t_q <= sr;
          ST_STSD: a_q  <= W1'(diff);
          ST_STST: b_q  <= W1'(diff);
          ST_SDSD: c_q  <= W1'(diff);
          ST_AA: begin
            aa_q <= mp_q[WX-1:0];
            d_q  <= (WX+1)'(diff);
          end
          ST_DB:   den_q <= mp_q;
          ST_NN:   nn_q  <= mp_q[W1-1:0];
          ST_NUM:  num_q <= {mp_q[WN-33:0], 32'd0};
          default: begin
          end
        endcase
      end
    end else if (state_q == B_DIV) begin
      num_q <= {num_q[WN-2:0], 1'b0};
      if (rs >= {1'b0, den_q}) begin
        rem_q <= rs - {1'b0, den_q};
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rs;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end else if (state_q == B_SQRT) begin
      quo_q <= {quo_q[61:0], 2'b00};
      if (rs2 >= test) begin
        srem_q <= rs2 - test;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= rs2;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if ((state_q == B_MUL) && mul_done && (step_q == ST_NUM)) begin
      rem_q <= '0;
      quo_q <= '0;
    end
    if ((state_q == B_DIV) && (cnt_q == CW'(WN - 1))) begin
      srem_q <= '0;
      root_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= ST_NSDT;
      ld_q    <= 1'b0;
      deg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            state_q <= B_MUL;
            step_q  <= ST_NSDT;
            ld_q    <= 1'b1;
            deg_q   <= 1'b0;
            ovf_q   <= 1'b0;
          end
        end
        B_MUL: begin
          if (ld_q) begin
            ld_q <= 1'b0;
          end else if (mul_done) begin
            ld_q   <= 1'b1;
            step_q <= step_q + 1'b1;
            if ((step_q == ST_AA) && !(bpos && dpos)) begin
              deg_q   <= 1'b1;
              ld_q    <= 1'b0;
              state_q <= B_OUT;
            end else if (step_q == ST_NUM) begin
              ld_q    <= 1'b0;
              cnt_q   <= '0;
              state_q <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (quo_q[63]) begin
            ovf_q <= 1'b1;
          end
          if (cnt_q == CW'(WN - 1)) begin
            cnt_q   <= '0;
            state_q <= B_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_SQRT: begin
          if (cnt_q == CW'(31)) begin
            state_q <= B_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_OUT: begin
          if (!res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/template_detection_criterion.sv =====
// Top level of the sliding template detection criterion block.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ----------------------------------------------
//  input     push / full          cmd_i, tap_index_i, sample_value_i
//  result    empty / pop          criterion_o (signed Q16.16), degenerate_o
//  config    cfg_we_i             cfg_wdata_i (template length, clamped 2..MAX_TAPS)
//
// A restart leaves full low. A tap write and a data sample each hold full high
// while they are stored; when the window is full, a data sample is followed by a
// dot product pass over the template length n and the job hand-off, with one
// multiply-accumulate per tap on the template and window memories' read ports. A
// configuration write starts a pass that rebuilds the template sums, with full
// held high meanwhile.
// The back end works one job at a time: up to 11 multiplier loads of the shift-add
// multiplier, a long division of one numerator bit per cycle and a 32-bit square
// root; this work sets the sustained rate when every sample yields a result.
// Two-entry queues between the front and back ends and in front of the result
// port let either side stall on its own. Reset clears the template store (entries
// read as zero until written), all sums and the window, and sets the length to 64
// (or MAX_TAPS if that is smaller).
`default_nettype none
module template_detection_criterion #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [tdc_pkg::LEN_BITS-1:0]          cfg_wdata_i,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [1:0]                            cmd_i,
  input  wire logic [tdc_pkg::TAP_IDX_BITS-1:0]      tap_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_value_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [tdc_pkg::CRIT_BITS-1:0]       criterion_o,
  output logic                                       degenerate_o
);
  import tdc_pkg::*;

  localparam int JW = job_width(MAX_TAPS, SAMPLE_BITS);

  // Jobs travel from the front end to the back end through a small queue. A job
  // stays at the head of that queue until its result has been queued.
  logic          job_push, job_full, job_pop, job_empty;
  logic [JW-1:0] job_in, job_out;
  logic          res_push, res_full;
  logic [RES_BITS-1:0] res_in, res_out;

  tdc_front #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .tap_index_i   (tap_index_i),
    .sample_value_i(sample_value_i),
    .job_push_o    (job_push),
    .job_data_o    (job_in),
    .job_full_i    (job_full)
  );

  tdc_fifo #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  tdc_back #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_data_i (job_out),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .res_push_o (res_push),
    .res_data_o (res_in),
    .res_full_i (res_full)
  );

  // The result queue holds finished results while the consumer stalls.
  tdc_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign criterion_o  = res_out[CRIT_BITS-1:0];
  assign degenerate_o = res_out[CRIT_BITS];

  // The back end never queues a result into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result queued while result queue full");

  // The front end never queues a job into a full job queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("job queued while job queue full");

  // A length write starts the template sum pass, so no transaction is taken next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> full)
    else $error("input not blocked during template sum pass");

  // A job leaves its queue only together with its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> (res_push && !job_empty))
    else $error("job dropped without a result");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sliding template detection criterion block.
`default_nettype none

// Tracks the template, window and sums of the block and holds the criterion
// results that accepted data samples are still owed.
class criterion_scoreboard;
  typedef logic signed [319:0] wide_t;
  typedef struct packed {
    logic signed [31:0] crit;
    logic               degen;
  } crit_t;

  int     taps_in_use;
  longint tmpl[64];
  longint ring[64];
  int     wr_ptr;
  int     filled;
  longint d_sum, d_sq_sum, t_sum, t_sq_sum;
  crit_t  owed[$];
  int     errors;

  function new();
    foreach (tmpl[i]) begin
      tmpl[i] = 0;
      ring[i] = 0;
    end
    taps_in_use = tdc_pkg::LEN_RESET;
    t_sum = 0;
    t_sq_sum = 0;
    errors = 0;
    clear_window();
  endfunction

  function void clear_window();
    wr_ptr = 0;
    filled = 0;
    d_sum = 0;
    d_sq_sum = 0;
  endfunction

  // A length write clamps, rebuilds the template sums and restarts the window.
  function void set_length(logic [tdc_pkg::LEN_BITS-1:0] value);
    int v;
    v = int'(value);
    if (v < 2) v = 2;
    if (v > 64) v = 64;
    taps_in_use = v;
    t_sum = 0;
    t_sq_sum = 0;
    for (int i = 0; i < taps_in_use; i++) begin
      t_sum += tmpl[i];
      t_sq_sum += tmpl[i] * tmpl[i];
    end
    clear_window();
  endfunction

  // Least-squares fit of the template to the window; returns scale over
  // standard error in Q16.16, computed exactly in wide integers.
  function crit_t fit_criterion(longint dot);
    wide_t n, a, b, c, d, den, num, trial;
    logic [32:0] q;
    crit_t r;
    n = wide_t'(taps_in_use);
    a = n * wide_t'(dot) - wide_t'(t_sum) * wide_t'(d_sum);
    b = n * wide_t'(t_sq_sum) - wide_t'(t_sum) * wide_t'(t_sum);
    c = n * wide_t'(d_sq_sum) - wide_t'(d_sum) * wide_t'(d_sum);
    d = c * b - a * a;
    r.crit = '0;
    r.degen = 1'b1;
    if (b <= 0 || d <= 0) return r;
    den = b * d;
    num = (a * a * n * (n - 1)) <<< 32;
    q = '0;
    // Bitwise square root: keep each bit whose square still fits.
    for (int bit_pos = 31; bit_pos >= 0; bit_pos--) begin
      trial = wide_t'(q | (33'd1 << bit_pos));
      if (num - trial * trial * den >= 0) q = trial[32:0];
    end
    r.degen = 1'b0;
    if (a < 0) r.crit = (q >= 33'h80000000) ? tdc_pkg::CRIT_NEG_SAT : -q[31:0];
    else r.crit = (q > 33'h7FFFFFFF) ? tdc_pkg::CRIT_POS_SAT : q[31:0];
    return r;
  endfunction

  function void note_input(logic [1:0] cmd, logic [5:0] idx, logic signed [15:0] val);
    longint x, old, dot;
    int base;
    x = longint'(val);
    case (cmd)
      tdc_pkg::CMD_TAP: begin
        old = tmpl[idx];
        if (idx < taps_in_use) begin
          t_sum += x - old;
          t_sq_sum += x * x - old * old;
        end
        tmpl[idx] = x;
      end
      tdc_pkg::CMD_RESTART: clear_window();
      tdc_pkg::CMD_SAMPLE: begin
        if (filled >= taps_in_use) begin
          old = ring[(wr_ptr + 64 - taps_in_use) % 64];
          d_sum -= old;
          d_sq_sum -= old * old;
        end
        ring[wr_ptr] = x;
        wr_ptr = (wr_ptr + 1) % 64;
        d_sum += x;
        d_sq_sum += x * x;
        if (filled < taps_in_use) filled++;
        if (filled == taps_in_use) begin
          base = (wr_ptr + 64 - taps_in_use) % 64;
          dot = 0;
          for (int j = 0; j < taps_in_use; j++) dot += tmpl[j] * ring[(base + j) % 64];
          owed = {owed, fit_criterion(dot)};
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic signed [31:0] crit, logic degen);
    crit_t e;
    if (owed.size() == 0) begin
      $display("%0t: result with none owed: criterion %0d degenerate %0b", $time, crit, degen);
      errors++;
      return;
    end
    e = owed.pop_front();
    if (crit !== e.crit) begin
      $display("%0t: criterion expected %0d actual %0d", $time, e.crit, crit);
      errors++;
    end
    if (degen !== e.degen) begin
      $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degen);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdc_pkg::*;

  // Command code that the block ignores; not part of the package enum.
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int         STALL_LIMIT = 20000;
  localparam int         DRAIN_CYCLES = 600;
  localparam int         ITEM_TARGET = 1850;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [LEN_BITS-1:0]          cfg_wdata_i = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic [1:0]                   cmd_i = CMD_TAP;
  logic [TAP_IDX_BITS-1:0]      tap_index_i = '0;
  logic signed [15:0]           sample_value_i = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic signed [CRIT_BITS-1:0]  criterion_o;
  logic                         degenerate_o;

  criterion_scoreboard sb = new();

  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 0;         // when set, both sides run without idling
  bit  long_hold_req = 0;   // asks the receiver for one long hold-off

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  template_detection_criterion dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full),
    .cmd_i(cmd_i), .tap_index_i(tap_index_i), .sample_value_i(sample_value_i),
    .empty(empty), .pop(pop),
    .criterion_o(criterion_o), .degenerate_o(degenerate_o)
  );

  // The monitor samples handshakes at the edge where they complete. Since
  // all drivers use nonblocking updates, the values seen here are the ones
  // the block itself saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_length(cfg_wdata_i);
      if (push && !full) sb.note_input(cmd_i, tap_index_i, sample_value_i);
      if (pop && !empty) sb.check_result(criterion_o, degenerate_o);
    end
  end

  // The watchdog ends the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Offers one input transaction and returns once it has been accepted.
  // push stays high afterwards, so back-to-back items need no toggle.
  task automatic send(logic [1:0] cmd, logic [5:0] idx, logic signed [15:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= cmd;
    tap_index_i <= idx;
    sample_value_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (cmd != CMD_IGNORED) items_sent++;
  endtask

  // Register writes happen only with the block idle: every owed result has
  // arrived and the last tap or sample has had time to leave the pipeline.
  task automatic write_length(logic [LEN_BITS-1:0] value);
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] draw_value(int flavor, logic signed [15:0] base);
    case (flavor)
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      2: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return base;
    endcase
  endfunction

  // Receiver: pops with random gaps, and once holds off for a long stretch
  // so that the internal queues fill and full is driven high.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 0;
        pop <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    int len, flavor, extra;
    bit hold_done;
    logic signed [15:0] base;
    logic [LEN_BITS-1:0] len_code;
    hold_done = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a three-tap template with extreme taps, extreme data,
    // a tap past the length in use, a restart, an ignored command, a flat
    // window (zero fit error) and a flat template (zero variance).
    write_length(7'd3);
    send(CMD_TAP, 6'd0, 16'sh7FFF);
    send(CMD_TAP, 6'd1, -16'sh8000);
    send(CMD_TAP, 6'd2, 16'sd0);
    send(CMD_TAP, 6'd63, -16'sd1);
    send(CMD_SAMPLE, 6'd0, -16'sh8000);
    send(CMD_SAMPLE, 6'd0, 16'sh7FFF);
    send(CMD_SAMPLE, 6'd0, 16'sd0);
    send(CMD_SAMPLE, 6'd0, 16'sd1);
    send(CMD_SAMPLE, 6'd0, -16'sd1);
    send(CMD_RESTART, 6'd0, 16'sd0);
    send(CMD_IGNORED, 6'd42, 16'sh5555);
    send(CMD_SAMPLE, 6'd0, 16'sd5);
    send(CMD_SAMPLE, 6'd0, 16'sd5);
    send(CMD_SAMPLE, 6'd0, 16'sd5);
    send(CMD_TAP, 6'd0, 16'sd7);
    send(CMD_TAP, 6'd1, 16'sd7);
    send(CMD_TAP, 6'd2, 16'sd7);
    send(CMD_SAMPLE, 6'd0, 16'sd1);
    send(CMD_SAMPLE, 6'd0, 16'sd2);
    send(CMD_SAMPLE, 6'd0, -16'sd3);

    // Random phases: a length (including out-of-range codes), a template
    // load, then a stream of samples with occasional restarts and noise.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0: len_code = 7'($urandom_range(0, 1));
        1: len_code = 7'($urandom_range(65, 127));
        2: len_code = 7'd64;
        3: len_code = 7'd2;
        default: len_code = 7'($urandom_range(2, 10));
      endcase
      write_length(len_code);
      len = (len_code < 2) ? 2 : (len_code > 64) ? 64 : int'(len_code);
      no_gaps = ($urandom_range(0, 3) == 0);

      flavor = $urandom_range(0, 4);
      base = 16'($urandom);
      for (int i = 0; i < len; i++) send(CMD_TAP, 6'(i), draw_value(flavor, base));
      // A few writes anywhere, past the length in use included.
      repeat ($urandom_range(0, 3)) send(CMD_TAP, 6'($urandom_range(0, 63)), 16'($urandom));

      extra = (len > 16) ? $urandom_range(5, 15) : $urandom_range(15, 45);
      flavor = $urandom_range(0, 4);
      base = 16'($urandom);
      for (int i = 0; i < len + extra; i++) begin
        case ($urandom_range(0, 39))
          0: send(CMD_RESTART, 6'($urandom), 16'($urandom));
          1: send(CMD_IGNORED, 6'($urandom), 16'($urandom));
          2: send(CMD_TAP, 6'($urandom_range(0, 63)), 16'($urandom));
          default: send(CMD_SAMPLE, 6'($urandom), draw_value(flavor, base));
        endcase
      end

      if (!hold_done && items_sent > ITEM_TARGET / 2 && len <= 10) begin
        // Hold the receiver while the sender keeps streaming samples.
        hold_done = 1;
        long_hold_req = 1;
        no_gaps = 1;
        for (int i = 0; i < 40; i++) send(CMD_SAMPLE, 6'($urandom), 16'($urandom));
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/tdc_pkg.sv
design/tdc_fifo.sv
design/tdc_front.sv
design/tdc_back.sv
design/template_detection_criterion.sv
tb/tb_top.sv
